/* rtl/woa_pkg.sv */
`timescale 1ns / 1ps

package woa_pkg;

  localparam int NUM_INPUTS  = 8;
  localparam int NUM_OUTPUTS = 10;
  localparam int PORT_W      = 4;
  localparam int SRC_W       = $clog2(NUM_INPUTS);

  typedef struct packed {
    logic [NUM_INPUTS-1:0] request_valid_mask;
    logic [NUM_INPUTS-1:0] release_mask;
    logic [PORT_W-1:0]     wanted_port_0;
    logic [PORT_W-1:0]     wanted_port_1;
    logic [PORT_W-1:0]     wanted_port_2;
    logic [PORT_W-1:0]     wanted_port_3;
    logic [PORT_W-1:0]     wanted_port_4;
    logic [PORT_W-1:0]     wanted_port_5;
    logic [PORT_W-1:0]     wanted_port_6;
    logic [PORT_W-1:0]     wanted_port_7;
  } in_item_t;

  typedef struct packed {
    logic [NUM_INPUTS-1:0]  grant_mask;
    logic [NUM_OUTPUTS-1:0] connected_mask;
    logic [SRC_W-1:0]       source_of_out_0;
    logic [SRC_W-1:0]       source_of_out_1;
    logic [SRC_W-1:0]       source_of_out_2;
    logic [SRC_W-1:0]       source_of_out_3;
    logic [SRC_W-1:0]       source_of_out_4;
    logic [SRC_W-1:0]       source_of_out_5;
    logic [SRC_W-1:0]       source_of_out_6;
    logic [SRC_W-1:0]       source_of_out_7;
    logic [SRC_W-1:0]       source_of_out_8;
    logic [SRC_W-1:0]       source_of_out_9;
  } out_item_t;

  // Per-output lock state plus the source value each output last drove
  typedef struct packed {
    logic [NUM_OUTPUTS-1:0]            locked;
    logic [NUM_OUTPUTS-1:0][SRC_W-1:0] owner;
    logic [NUM_OUTPUTS-1:0][SRC_W-1:0] last_src;
  } alloc_state_t;

endpackage

/* rtl/woa_alloc.sv */
`timescale 1ns / 1ps

module woa_alloc (
  input  woa_pkg::in_item_t     item,
  input  woa_pkg::alloc_state_t state,
  output woa_pkg::alloc_state_t state_next,
  output woa_pkg::out_item_t    result
);
  import woa_pkg::*;

  logic [NUM_INPUTS-1:0][PORT_W-1:0] port;
  logic [NUM_OUTPUTS-1:0]            keep;
  logic [NUM_OUTPUTS-1:0]            won;
  logic [NUM_OUTPUTS-1:0][SRC_W-1:0] winner;
  logic [NUM_INPUTS-1:0]             grant;

  always_comb begin
    port[0] = item.wanted_port_0;
    port[1] = item.wanted_port_1;
    port[2] = item.wanted_port_2;
    port[3] = item.wanted_port_3;
    port[4] = item.wanted_port_4;
    port[5] = item.wanted_port_5;
    port[6] = item.wanted_port_6;
    port[7] = item.wanted_port_7;
  end

  always_comb begin
    grant      = '0;
    state_next = state;
    for (int j = 0; j < NUM_OUTPUTS; j++) begin
      keep[j]   = state.locked[j] && !item.release_mask[state.owner[j]];
      won[j]    = 1'b0;
      winner[j] = '0;
      // scan from the top so the lowest-numbered requester wins
      for (int i = NUM_INPUTS - 1; i >= 0; i--) begin
        if (item.request_valid_mask[i] && port[i] == PORT_W'(j)) begin
          won[j]    = 1'b1;
          winner[j] = SRC_W'(i);
        end
      end
      if (keep[j]) begin
        grant[state.owner[j]]  = 1'b1;
        state_next.last_src[j] = state.owner[j];
      end else if (won[j]) begin
        state_next.locked[j]   = 1'b1;
        state_next.owner[j]    = winner[j];
        state_next.last_src[j] = winner[j];
        grant[winner[j]]       = 1'b1;
      end else begin
        state_next.locked[j] = 1'b0;
        state_next.owner[j]  = '0;
      end
    end
  end

  always_comb begin
    result.grant_mask      = grant;
    result.connected_mask  = state_next.locked;
    result.source_of_out_0 = state_next.last_src[0];
    result.source_of_out_1 = state_next.last_src[1];
    result.source_of_out_2 = state_next.last_src[2];
    result.source_of_out_3 = state_next.last_src[3];
    result.source_of_out_4 = state_next.last_src[4];
    result.source_of_out_5 = state_next.last_src[5];
    result.source_of_out_6 = state_next.last_src[6];
    result.source_of_out_7 = state_next.last_src[7];
    result.source_of_out_8 = state_next.last_src[8];
    result.source_of_out_9 = state_next.last_src[9];
  end

endmodule

/* rtl/wormhole_output_arbiter_unit.sv */
`timescale 1ns / 1ps

// Fixed-priority wormhole switch allocator, 8 inputs to 10 outputs. One item is
// taken every clock unless in_stall holds it; an accepted item is held in an input
// register, allocated in a single combinational pass against the output lock
// state, and its result is then offered from the result register. The pass
// does release, hold of locked outputs and a lowest-input-wins pick for each
// free output. An unconnected output repeats the source it last drove. No
// clearing pass after reset.
module wormhole_output_arbiter_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  woa_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output woa_pkg::out_item_t  out_item
);
  import woa_pkg::*;

  logic         s1_valid;
  in_item_t     s1_item;
  alloc_state_t state;
  alloc_state_t state_next;
  out_item_t    result;
  logic         advance;

  woa_alloc u_alloc (
    .item       (s1_item),
    .state      (state),
    .state_next (state_next),
    .result     (result)
  );

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= '0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
        state     <= state_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= in_item;
    end
    if (advance) begin
      out_item <= result;
    end
  end

  // lock state must mirror the connections just reported
  assert property (@(posedge clk) disable iff (rst)
    advance |=> state.locked == out_item.connected_mask)
    else $error("lock state out of step with connected mask");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_item.grant_mask == '0) == (out_item.connected_mask == '0)))
    else $error("grant and connection masks disagree");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.connected_mask[0] |->
      out_item.grant_mask[out_item.source_of_out_0])
    else $error("output 0 connected to an input without grant");

  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled with room to advance");

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
  import woa_pkg::*;

  localparam int QUIET_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_MAX   = 10;

  logic      clk;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  wormhole_output_arbiter_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // Predicted allocator state
  logic [NUM_OUTPUTS-1:0] port_locked;
  logic [SRC_W-1:0]       port_owner    [NUM_OUTPUTS];
  logic [SRC_W-1:0]       port_last_src [NUM_OUTPUTS];

  out_item_t pending_allocs [$];
  int        error_count  = 0;
  int        quiet_cycles = 0;
  int        hold_cycles  = 0;
  bit        idle_on      = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [PORT_W-1:0] wanted_port(input in_item_t it, input int i);
    return it[PORT_W*(NUM_INPUTS-1-i) +: PORT_W];
  endfunction

  function automatic logic [SRC_W-1:0] source_slot(input out_item_t r, input int j);
    return r[SRC_W*(NUM_OUTPUTS-1-j) +: SRC_W];
  endfunction

  // Release, hold locked outputs, then lowest input wins each free output
  function automatic out_item_t allocate_ports(input in_item_t it);
    out_item_t r;
    logic      found;
    int        i;
    int        j;
    r = '0;
    for (j = 0; j < NUM_OUTPUTS; j++) begin
      if (port_locked[j] && it.release_mask[port_owner[j]]) begin
        port_locked[j] = 1'b0;
        port_owner[j]  = '0;
      end
    end
    for (j = 0; j < NUM_OUTPUTS; j++) begin
      if (port_locked[j]) begin
        r.grant_mask[port_owner[j]] = 1'b1;
        r.connected_mask[j]         = 1'b1;
        port_last_src[j]            = port_owner[j];
      end
    end
    for (j = 0; j < NUM_OUTPUTS; j++) begin
      if (!port_locked[j]) begin
        found = 1'b0;
        for (i = 0; i < NUM_INPUTS; i++) begin
          if (!found && it.request_valid_mask[i] && wanted_port(it, i) == j) begin
            found               = 1'b1;
            port_locked[j]      = 1'b1;
            port_owner[j]       = SRC_W'(i);
            port_last_src[j]    = SRC_W'(i);
            r.grant_mask[i]     = 1'b1;
            r.connected_mask[j] = 1'b1;
          end
        end
      end
    end
    for (j = 0; j < NUM_OUTPUTS; j++)
      r[SRC_W*(NUM_OUTPUTS-1-j) +: SRC_W] = port_last_src[j];
    return r;
  endfunction

  function automatic in_item_t random_item(input bit tidy);
    in_item_t it;
    int       i;
    it = '0;
    it.request_valid_mask = 8'($urandom);
    if (tidy) begin
      // keep releases sparse so that locks live for a while
      case ($urandom_range(0, 7))
        0, 1:    it.release_mask = 8'(1 << $urandom_range(0, NUM_INPUTS - 1));
        2:       it.release_mask = 8'($urandom);
        default: it.release_mask = '0;
      endcase
      for (i = 0; i < NUM_INPUTS; i++)
        it[PORT_W*(NUM_INPUTS-1-i) +: PORT_W] = ($urandom_range(0, 7) != 0) ?
            PORT_W'($urandom_range(0, NUM_OUTPUTS - 1)) :
            PORT_W'($urandom_range(NUM_OUTPUTS, 15));
    end else begin
      it.release_mask = 8'($urandom);
      for (i = 0; i < NUM_INPUTS; i++)
        it[PORT_W*(NUM_INPUTS-1-i) +: PORT_W] = PORT_W'($urandom);
    end
    return it;
  endfunction

  // Check results, then record newly accepted items
  always @(posedge clk) begin
    out_item_t exp_r;
    logic      bad;
    int        j;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_allocs.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_MAX)
            $display("tb: result %h with none outstanding", out_item);
        end else begin
          exp_r = pending_allocs.pop_front();
          bad = (out_item.grant_mask !== exp_r.grant_mask) ||
                (out_item.connected_mask !== exp_r.connected_mask);
          for (j = 0; j < NUM_OUTPUTS; j++)
            if (source_slot(out_item, j) !== source_slot(exp_r, j))
              bad = 1'b1;
          if (bad) begin
            error_count++;
            if (error_count <= REPORT_MAX)
              $display("tb: mismatch grant %h/%h connected %h/%h sources %h/%h (exp/got)",
                       exp_r.grant_mask, out_item.grant_mask,
                       exp_r.connected_mask, out_item.connected_mask,
                       exp_r[SRC_W*NUM_OUTPUTS-1:0], out_item[SRC_W*NUM_OUTPUTS-1:0]);
          end
        end
      end
      if (in_valid && !in_stall)
        pending_allocs.push_back(allocate_ports(in_item));
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Result side: long hold when asked, otherwise short random stall bursts while idle_on
  initial begin
    int burst = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(0, 4);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(input in_item_t it);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic await_results();
    in_valid <= 1'b0;
    while (pending_allocs.size() != 0) @(posedge clk);
  endtask

  task automatic run_corner_items();
    in_item_t corner [17] = '{
      in_item_t'({8'h00, 8'h00, 32'h0000_0000}),
      in_item_t'({8'hFF, 8'h00, 32'h0000_0000}),  // all want output 0
      in_item_t'({8'hFF, 8'hFF, 32'h0123_4567}),  // release and win again
      in_item_t'({8'h00, 8'h00, 32'h89AB_CDEF}),  // hold all locks
      in_item_t'({8'hFF, 8'h00, 32'h8989_8989}),  // second output for inputs 0, 1
      in_item_t'({8'h00, 8'h01, 32'h0000_0000}),  // free both of input 0
      in_item_t'({8'h80, 8'h00, 32'h0000_0008}),
      in_item_t'({8'h81, 8'h80, 32'h8000_0008}),  // lower input takes freed output
      in_item_t'({8'hFF, 8'h00, 32'hABCD_EFAB}),  // ports out of range
      in_item_t'({8'hFF, 8'hFF, 32'hFFFF_FFFF}),
      in_item_t'({8'h00, 8'hFF, 32'h0000_0000}),  // release with nothing owned
      in_item_t'({8'hFF, 8'h00, 32'h9999_9999}),
      in_item_t'({8'hFF, 8'h00, 32'h7654_3210}),
      in_item_t'({8'h00, 8'hAA, 32'h0000_0000}),
      in_item_t'({8'h55, 8'h00, 32'h1111_1111}),  // contend for a held output
      in_item_t'({8'hFF, 8'hFF, 32'hFFFF_FFFF}),
      in_item_t'({8'hFF, 8'h00, 32'h0000_0000})
    };
    foreach (corner[k])
      send_item(corner[k]);
  endtask

  task automatic run_backpressure();
    int k;
    hold_cycles = 60;
    for (k = 0; k < 30; k++)
      send_item(random_item(1'b1));
    await_results();
  endtask

  task automatic run_random_traffic(input int count);
    int k;
    for (k = 0; k < count; k++)
      send_item(random_item($urandom_range(0, 7) != 0));
  endtask

  initial begin
    int k;
    port_locked = '0;
    for (k = 0; k < NUM_OUTPUTS; k++) begin
      port_owner[k]    = '0;
      port_last_src[k] = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    run_corner_items();
    await_results();
    run_backpressure();
    run_random_traffic(1160);
    await_results();
    idle_on = 1'b0;
    run_random_traffic(200);
    await_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
